>>> rtl/tls_pkg.sv
// Shared types, codes and helper functions for the streaming token lexer.
`default_nettype none

package tls_pkg;

    // Lexer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;
    localparam logic [1:0] MODE_ERR  = 2'd3;

    // Token kinds
    localparam logic [2:0] TK_NUM     = 3'd0;
    localparam logic [2:0] TK_PUNCT   = 3'd1;
    localparam logic [2:0] TK_KEYWORD = 3'd2;
    localparam logic [2:0] TK_IDENT   = 3'd3;
    localparam logic [2:0] TK_EOF     = 3'd4;
    localparam logic [2:0] TK_ERROR   = 3'd5;

    // Keyword ids
    localparam logic KW_I32    = 1'b0;
    localparam logic KW_RETURN = 1'b1;

    localparam logic [15:0] LEN_MAX   = 16'hFFFF;
    localparam logic [62:0] VALUE_MAX = {63{1'b1}};
    localparam logic [15:0] I32_LEN    = 16'd3;
    localparam logic [15:0] RETURN_LEN = 16'd6;

    // Output queue geometry
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] pos;
        logic [15:0] start;
        logic [15:0] len;
        logic [62:0] acc;
        logic [1:0]  kwflags;
    } tls_state_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [62:0] number_value;
        logic [7:0]  punct_char;
        logic        keyword_id;
        logic        last;
    } tls_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
    endfunction

    // Characters of "i32"
    function automatic logic [7:0] i32_char(input logic [1:0] i);
        logic [7:0] ch;
        case (i)
            2'd0:    ch = 8'h69;
            2'd1:    ch = 8'h33;
            2'd2:    ch = 8'h32;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "return"
    function automatic logic [7:0] return_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h75;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Drop keyword candidates that the byte at this index does not match
    function automatic logic [1:0] kw_match(input logic [1:0] flags, input logic [7:0] c,
                                            input logic [15:0] idx);
        logic [1:0] f;
        f = flags;
        if (!((idx < I32_LEN) && (c == i32_char(idx[1:0]))))
            f[0] = 1'b0;
        if (!((idx < RETURN_LEN) && (c == return_char(idx[2:0]))))
            f[1] = 1'b0;
        return f;
    endfunction

    // acc*10 + digit, saturating at the largest 63-bit value
    function automatic logic [62:0] acc_digit(input logic [62:0] acc, input logic [7:0] c);
        logic [66:0] wide;
        logic [7:0]  d8;
        d8   = c - 8'h30;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {63'b0, d8[3:0]};
        return (|wide[66:63]) ? VALUE_MAX : wide[62:0];
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v < LEN_MAX) ? v + 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/token_lexer_stream_top.sv
// Top level of the streaming token lexer: input register, lexer state and result queue.
// An accepted item waits in the input register until the queue has room for its results.
// Throughput: one item per cycle while the queue has room; the one-result-per-cycle output
// port sets the limit when items give two results, with a 4-entry result queue in between.
// The held item waits, and further input stalls, while the queue holds more than 2 results.
// Reset (aresetn low, synchronous): lexer idle at offset 0, queue and input stage empty.
`default_nettype none

module token_lexer_stream_top
    import tls_pkg::*;
#(
    parameter int unsigned MAX_TEXT = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [7:0]  s_text_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_token_kind,
    output logic [15:0]      m_start_offset,
    output logic [15:0]      m_token_length,
    output logic [62:0]      m_number_value,
    output logic [7:0]       m_punct_char,
    output logic             m_keyword_id,
    output logic             m_last
);

    localparam int unsigned PosLimitInt = (MAX_TEXT - 1 > 65535) ? 65535 : MAX_TEXT - 1;
    localparam logic [15:0] POS_LIMIT   = 16'(PosLimitInt);

    logic          in_valid_reg, in_valid_next;
    logic          in_kind_reg;
    logic [7:0]    in_byte_reg;
    tls_state_t    state_reg, state_next;
    tls_result_t   res0, res1;
    logic [1:0]    res_count;
    tls_result_t   q_mem [QDEPTH];
    logic [QAW-1:0] head_reg, head_next;
    logic [QAW-1:0] tail_reg, tail_next;
    logic [QAW:0]  count_reg, count_next;
    logic          proc;
    logic          pop;
    logic [1:0]    push_count;
    tls_result_t   head_res;

    // Process the held item only when the queue has room for two results
    assign proc    = in_valid_reg && (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign s_ready = !in_valid_reg || proc;
    assign pop     = m_valid && m_ready;
    assign push_count = proc ? res_count : 2'd0;

    tls_step u_step (
        .cur       (state_reg),
        .in_kind   (in_kind_reg),
        .in_byte   (in_byte_reg),
        .pos_limit (POS_LIMIT),
        .nxt       (state_next),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    // Input register
    always_comb begin
        if (s_valid && s_ready)
            in_valid_next = 1'b1;
        else if (proc)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_text_byte;
        end
    end

    // Queue pointers and occupancy
    always_comb begin
        tail_next  = tail_reg + QAW'(push_count);
        head_next  = head_reg + QAW'(pop);
        count_next = count_reg + (QAW+1)'(push_count) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (proc)
                state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write results into the queue
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0)
            q_mem[tail_reg] <= res0;
        if (push_count == 2'd2)
            q_mem[tail_reg + QAW'(1)] <= res1;
    end

    // Drive the result port from the queue head
    assign head_res       = q_mem[head_reg];
    assign m_valid        = (count_reg != '0);
    assign m_token_kind   = head_res.token_kind;
    assign m_start_offset = head_res.start_offset;
    assign m_token_length = head_res.token_length;
    assign m_number_value = head_res.number_value;
    assign m_punct_char   = head_res.punct_char;
    assign m_keyword_id   = head_res.keyword_id;
    assign m_last         = head_res.last;

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    // An eof result always closes its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == TK_EOF) |-> m_last)
        else $error("eof result without last");

    // End mark returns the lexer to offset zero and idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_kind_reg |=> (state_reg.pos == 16'd0) && (state_reg.mode == MODE_IDLE))
        else $error("lexer not reset after end mark");

    // Discarding mode yields nothing for text bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !in_kind_reg && (state_reg.mode == MODE_ERR) |-> (push_count == 2'd0))
        else $error("result produced while discarding");

endmodule

`default_nettype wire

>>> rtl/tls_step.sv
// Per-item lexer step: next state and up to two results for one input item.
`default_nettype none

module tls_step
    import tls_pkg::*;
(
    input  tls_state_t  cur,
    input  logic        in_kind,
    input  logic [7:0]  in_byte,
    input  logic [15:0] pos_limit,
    output tls_state_t  nxt,
    output tls_result_t res0,
    output tls_result_t res1,
    output logic [1:0]  res_count
);

    tls_result_t flush_res;
    tls_result_t new_res;
    logic        have_flush;
    logic        have_new;
    logic        dig;
    logic        alpha;
    logic        extend;

    assign dig   = is_digit(in_byte);
    assign alpha = is_alpha(in_byte);

    // Build the result for the pending number or word
    always_comb begin
        flush_res              = '0;
        flush_res.start_offset = cur.start;
        flush_res.token_length = cur.len;
        if (cur.mode == MODE_NUM) begin
            flush_res.token_kind   = TK_NUM;
            flush_res.number_value = cur.acc;
        end else if (cur.kwflags[0] && (cur.len == I32_LEN)) begin
            flush_res.token_kind = TK_KEYWORD;
            flush_res.keyword_id = KW_I32;
        end else if (cur.kwflags[1] && (cur.len == RETURN_LEN)) begin
            flush_res.token_kind = TK_KEYWORD;
            flush_res.keyword_id = KW_RETURN;
        end else begin
            flush_res.token_kind = TK_IDENT;
        end
    end

    assign extend = ((cur.mode == MODE_NUM) && dig) ||
                    ((cur.mode == MODE_WORD) && (dig || alpha));

    // Advance the lexer by one item
    always_comb begin
        nxt        = cur;
        new_res    = '0;
        have_flush = 1'b0;
        have_new   = 1'b0;
        new_res.start_offset = cur.pos;
        if (in_kind) begin
            // End of text: flush, then eof, then back to reset state
            have_flush         = (cur.mode == MODE_NUM) || (cur.mode == MODE_WORD);
            have_new           = 1'b1;
            new_res.token_kind = TK_EOF;
            nxt                = '0;
        end else begin
            nxt.pos = (cur.pos < pos_limit) ? cur.pos + 16'd1 : cur.pos;
            if (cur.mode == MODE_ERR) begin
                // discard bytes until the end mark
            end else if (extend) begin
                if (cur.mode == MODE_NUM)
                    nxt.acc = acc_digit(cur.acc, in_byte);
                else
                    nxt.kwflags = kw_match(cur.kwflags, in_byte, cur.len);
                nxt.len = sat_inc(cur.len);
            end else begin
                have_flush = (cur.mode == MODE_NUM) || (cur.mode == MODE_WORD);
                nxt.mode   = MODE_IDLE;
                if (is_space(in_byte)) begin
                    // skip
                end else if (dig) begin
                    nxt.mode  = MODE_NUM;
                    nxt.start = cur.pos;
                    nxt.len   = 16'd1;
                    nxt.acc   = acc_digit('0, in_byte);
                end else if (is_punct(in_byte)) begin
                    have_new                = 1'b1;
                    new_res.token_kind      = TK_PUNCT;
                    new_res.token_length    = 16'd1;
                    new_res.punct_char      = in_byte;
                end else if (alpha) begin
                    nxt.mode    = MODE_WORD;
                    nxt.start   = cur.pos;
                    nxt.len     = 16'd1;
                    nxt.kwflags = kw_match(2'b11, in_byte, 16'd0);
                end else begin
                    have_new             = 1'b1;
                    new_res.token_kind   = TK_ERROR;
                    new_res.token_length = 16'd1;
                    new_res.punct_char   = in_byte;
                    nxt.mode             = MODE_ERR;
                end
            end
        end
    end

    // Order results: pending token first, mark the final one
    always_comb begin
        res_count = {1'b0, have_flush} + {1'b0, have_new};
        res0      = have_flush ? flush_res : new_res;
        res1      = new_res;
        if (have_flush && have_new)
            res1.last = 1'b1;
        else
            res0.last = 1'b1;
    end

endmodule

`default_nettype wire
